### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed outside reset");

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hdl/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// Types and constants shared by the pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

  localparam int PIX_W      = 8;
  localparam int OFFSET_W   = 9;
  localparam int GAIN_W     = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CHAN   = 3;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_OVERLAY  = 3'd2,
    MODE_SUBTRACT = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_SCALE    = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE   = 3'd0,
    REG_BLUE_OFFSET  = 3'd1,
    REG_GREEN_OFFSET = 3'd2,
    REG_RED_OFFSET   = 3'd3,
    REG_BLUE_GAIN    = 3'd4,
    REG_GREEN_GAIN   = 3'd5,
    REG_RED_GAIN     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] top_blue;
    logic [PIX_W-1:0] top_green;
    logic [PIX_W-1:0] top_red;
    logic [PIX_W-1:0] bottom_blue;
    logic [PIX_W-1:0] bottom_green;
    logic [PIX_W-1:0] bottom_red;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
  } pix_out_t;

  // Per-channel view of the configuration.
  typedef struct packed {
    mode_t               mode;
    logic [OFFSET_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
  } chan_cfg_t;

endpackage

### hdl/pbu_channel.sv
// ----------------------------------------------------------------------------
// pbu_channel
// Blend datapath for one color channel, purely combinational.
// ----------------------------------------------------------------------------
module pbu_channel (
  input  pbu_pkg::chan_cfg_t             cfg,
  input  logic [pbu_pkg::PIX_W-1:0]      a,
  input  logic [pbu_pkg::PIX_W-1:0]      b,
  output logic [pbu_pkg::PIX_W-1:0]      y
);
  import pbu_pkg::*;

  logic                invert;
  logic [PIX_W-1:0]    mul_x;
  logic [GAIN_W-1:0]   mul_y;
  logic [23:0]         prod;
  logic [16:0]         dnum;
  logic [16:0]         t;
  logic [24:0]         t257;
  logic [8:0]          q0;
  logic [16:0]         q0x255;
  logic [16:0]         rem;
  logic [8:0]          q;
  logic [PIX_W-1:0]    blend;
  logic [24:0]         scaled;
  logic [PIX_W-1:0]    scale_out;
  logic [9:0]          sum;
  logic [PIX_W-1:0]    add_out;
  logic [PIX_W-1:0]    sub_out;

  always_comb begin
    // screen and the upper half of overlay work on 255-x and complement back
    invert = (cfg.mode == MODE_SCREEN) || ((cfg.mode == MODE_OVERLAY) && b[PIX_W-1]);
    mul_x  = invert ? ~a : a;
    mul_y  = (cfg.mode == MODE_SCALE) ? cfg.gain
                                      : {{(GAIN_W-PIX_W){1'b0}}, (invert ? ~b : b)};
    prod   = {16'd0, mul_x} * {8'd0, mul_y};

    dnum = (cfg.mode == MODE_OVERLAY) ? {prod[15:0], 1'b0} : {1'b0, prod[15:0]};

    // round(n/255) == floor((n+127)/255); t*257>>16 is low by at most one
    t      = dnum + 17'd127;
    t257   = {8'd0, t} + {t, 8'd0};
    q0     = t257[24:16];
    q0x255 = {q0, 8'd0} - {8'd0, q0};
    rem    = t - q0x255;
    q      = q0 + {8'd0, (rem >= 17'd255)};
    blend  = invert ? ~q[PIX_W-1:0] : q[PIX_W-1:0];

    scaled    = {1'b0, prod} + 25'd128;
    scale_out = (|scaled[24:16]) ? {PIX_W{1'b1}} : scaled[15:8];

    // 10-bit two's complement covers -256..510
    sum     = {2'b00, a} + {cfg.offset[OFFSET_W-1], cfg.offset};
    add_out = sum[9] ? '0 : (sum[8] ? {PIX_W{1'b1}} : sum[7:0]);

    sub_out = (a > b) ? (a - b) : '0;

    case (cfg.mode)
      MODE_MULTIPLY,
      MODE_SCREEN,
      MODE_OVERLAY:  y = blend;
      MODE_SUBTRACT: y = sub_out;
      MODE_ADD:      y = add_out;
      MODE_SCALE:    y = scale_out;
      default:       y = a;
    endcase
  end

endmodule

### hdl/pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// pixel_blend_unit
// Per-pixel BGR blender: multiply, screen, overlay, subtract, add, scale.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result
//   register, and shows on result with done.
// Throughput: one item per clock; busy is low whenever rst is low.
// Reset (synchronous): pipeline emptied, mode multiply, offsets 0, gains 1.0.
// The receiver cannot stall; each result shows for exactly one cycle.
module pixel_blend_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  pbu_pkg::pix_in_t                 pixel,
  output logic                             done,
  output pbu_pkg::pix_out_t                result,
  input  logic                             cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pbu_pkg::*;

  mode_t               blend_mode;
  logic [OFFSET_W-1:0] offset [NUM_CHAN];
  logic [GAIN_W-1:0]   gain   [NUM_CHAN];

  logic                stage_valid;
  pix_in_t             stage_pix;

  logic [PIX_W-1:0]    top_ch [NUM_CHAN];
  logic [PIX_W-1:0]    bot_ch [NUM_CHAN];
  logic [PIX_W-1:0]    out_ch [NUM_CHAN];
  chan_cfg_t           ch_cfg [NUM_CHAN];

  logic                accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_MULTIPLY;
      for (int i = 0; i < NUM_CHAN; i++) begin
        offset[i] <= '0;
        gain[i]   <= GAIN_UNITY;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE:   blend_mode <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_BLUE_OFFSET:  offset[0]  <= cfg_data[OFFSET_W-1:0];
        REG_GREEN_OFFSET: offset[1]  <= cfg_data[OFFSET_W-1:0];
        REG_RED_OFFSET:   offset[2]  <= cfg_data[OFFSET_W-1:0];
        REG_BLUE_GAIN:    gain[0]    <= cfg_data[GAIN_W-1:0];
        REG_GREEN_GAIN:   gain[1]    <= cfg_data[GAIN_W-1:0];
        REG_RED_GAIN:     gain[2]    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stage_valid <= accept;
      done        <= stage_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_pix <= pixel;
    end
    if (stage_valid) begin
      result.out_blue  <= out_ch[0];
      result.out_green <= out_ch[1];
      result.out_red   <= out_ch[2];
    end
  end

  assign top_ch[0] = stage_pix.top_blue;
  assign top_ch[1] = stage_pix.top_green;
  assign top_ch[2] = stage_pix.top_red;
  assign bot_ch[0] = stage_pix.bottom_blue;
  assign bot_ch[1] = stage_pix.bottom_green;
  assign bot_ch[2] = stage_pix.bottom_red;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    assign ch_cfg[c] = '{mode: blend_mode, offset: offset[c], gain: gain[c]};

    pbu_channel u_chan (
      .cfg (ch_cfg[c]),
      .a   (top_ch[c]),
      .b   (bot_ch[c]),
      .y   (out_ch[c])
    );
  end

endmodule

### hdl/pbu_checker.sv
// ----------------------------------------------------------------------------
// pbu_checker
// Port-level timing checks for the pixel blend unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbu_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every accepted item comes out with done after the pipeline registers
  `ASSERT_CLK(a_item_out, (start && !busy) |=> ##1 done)

  // no result without a matching accepted item
  `ASSERT_CLK(a_no_spurious, done |-> $past(start && !busy, 2))

  // reset flushes the pipeline
  `ASSERT_ALWAYS(a_reset_flush, $past(rst) |-> !done)

endmodule

bind pixel_blend_unit pbu_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### sim/pixel_blend_checker.sv
// ----------------------------------------------------------------------------
// pixel_blend_checker
// Watches the pixel, result and register ports of the blend unit. It keeps
// its own copy of the registers, predicts one blended pixel per accepted
// item and compares every result, channel by channel, in arrival order.
// ----------------------------------------------------------------------------
module pixel_blend_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  pbu_pkg::pix_in_t               pixel,
  input  logic                           done,
  input  pbu_pkg::pix_out_t              result,
  input  logic                           cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbu_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count
);
  import pbu_pkg::*;

  logic [MODE_W-1:0]   mode_q;
  logic [OFFSET_W-1:0] offset_q [NUM_CHAN];
  logic [GAIN_W-1:0]   gain_q   [NUM_CHAN];
  pix_out_t            blended_q [$];
  string               chan_name [NUM_CHAN] = '{"blue", "green", "red"};

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
  end

  // n/255 rounded half up
  function automatic int round255(input int n);
    return (2 * n + 255) / 510;
  endfunction

  function automatic logic [PIX_W-1:0] mix_channel(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [OFFSET_W-1:0] offset,
                                                   input logic [GAIN_W-1:0] gain);
    int ta;
    int tb;
    int r;
    ta = int'(a);
    tb = int'(b);
    case (mode_q)
      MODE_MULTIPLY: r = round255(ta * tb);
      MODE_SCREEN:   r = 255 - round255((255 - ta) * (255 - tb));
      MODE_OVERLAY:  r = (tb <= 127) ? round255(2 * ta * tb)
                                     : 255 - round255(2 * (255 - ta) * (255 - tb));
      MODE_SUBTRACT: r = (ta > tb) ? ta - tb : 0;
      MODE_ADD: begin
        r = ta + int'($signed(offset));
        if (r < 0) r = 0;
        if (r > 255) r = 255;
      end
      MODE_SCALE: begin
        r = (ta * int'(gain) + 128) >>> 8;
        if (r > 255) r = 255;
      end
      default:       r = ta;  // unused codes pass the top pixel through
    endcase
    return r[PIX_W-1:0];
  endfunction

  function automatic pix_out_t blend_pixel(input pix_in_t p);
    pix_out_t o;
    o.out_blue  = mix_channel(p.top_blue,  p.bottom_blue,  offset_q[0], gain_q[0]);
    o.out_green = mix_channel(p.top_green, p.bottom_green, offset_q[1], gain_q[1]);
    o.out_red   = mix_channel(p.top_red,   p.bottom_red,   offset_q[2], gain_q[2]);
    return o;
  endfunction

  always @(posedge clk) begin
    pix_out_t            want;
    logic [PIX_W-1:0]    want_ch [NUM_CHAN];
    logic [PIX_W-1:0]    got_ch  [NUM_CHAN];
    if (rst) begin
      mode_q = MODE_MULTIPLY;
      for (int i = 0; i < NUM_CHAN; i++) begin
        offset_q[i] = '0;
        gain_q[i]   = GAIN_UNITY;
      end
      blended_q.delete();
    end else begin
      if (start && !busy)
        blended_q = {blended_q, blend_pixel(pixel)};
      if (done) begin
        result_count++;
        if (blended_q.size() == 0) begin
          fail_count++;
          $display("%0t: result %h with no item outstanding", $time, result);
        end else begin
          want       = blended_q.pop_front();
          want_ch[0] = want.out_blue;
          want_ch[1] = want.out_green;
          want_ch[2] = want.out_red;
          got_ch[0]  = result.out_blue;
          got_ch[1]  = result.out_green;
          got_ch[2]  = result.out_red;
          for (int i = 0; i < NUM_CHAN; i++)
            if (got_ch[i] !== want_ch[i]) begin
              fail_count++;
              $display("%0t: out_%s expected %0d got %0d", $time, chan_name[i],
                       want_ch[i], got_ch[i]);
            end
        end
      end
      // register writes come only while no item is in flight
      if (cfg_we) begin
        case (cfg_index)
          REG_BLEND_MODE:   mode_q      = cfg_data[MODE_W-1:0];
          REG_BLUE_OFFSET:  offset_q[0] = cfg_data[OFFSET_W-1:0];
          REG_GREEN_OFFSET: offset_q[1] = cfg_data[OFFSET_W-1:0];
          REG_RED_OFFSET:   offset_q[2] = cfg_data[OFFSET_W-1:0];
          REG_BLUE_GAIN:    gain_q[0]   = cfg_data[GAIN_W-1:0];
          REG_GREEN_GAIN:   gain_q[1]   = cfg_data[GAIN_W-1:0];
          REG_RED_GAIN:     gain_q[2]   = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = blended_q.size();
  end

endmodule

### sim/pixel_blend_unit_tb.sv
// ----------------------------------------------------------------------------
// pixel_blend_unit_tb
// Drives the blend unit with a short directed pass through every mode code,
// then random pixel bursts under random register settings, draining the
// pipeline before each reprogram. Checking lives in pixel_blend_checker.
// ----------------------------------------------------------------------------
module pixel_blend_unit_tb;
  import pbu_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  pix_in_t               pixel = '0;
  logic                  done;
  pix_out_t              result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLEND_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int result_count;
  int cycle_count = 0;
  int item_count = 0;
  int setting_count = 0;
  int mode_items [8] = '{default: 0};
  logic [MODE_W-1:0] cur_mode = MODE_MULTIPLY;

  always #5 clk = ~clk;

  pixel_blend_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel    (pixel),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pixel_blend_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pixel       (pixel),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // start stays high across back-to-back items; it drops only for a gap
  task automatic drive_pixel(input pix_in_t p, input int gap);
    @(negedge clk);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    item_count++;
    mode_items[cur_mode]++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_BLEND_MODE) cur_mode = data[MODE_W-1:0];
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [PIX_W-1:0] rand_chan;
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic pix_in_t rand_pixel;
    pix_in_t p;
    p.top_blue     = rand_chan();
    p.top_green    = rand_chan();
    p.top_red      = rand_chan();
    p.bottom_blue  = rand_chan();
    p.bottom_green = rand_chan();
    p.bottom_red   = rand_chan();
    return p;
  endfunction

  function automatic int pick_gap;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random upper bits ride along; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] rand_offset;
    logic [OFFSET_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 9'h0FF;   // +255
      1:       v = 9'h101;   // -255
      2:       v = 9'h100;   // -256, below the nominal range
      3:       v = 9'h000;
      default: v = OFFSET_W'($urandom);
    endcase
    return {7'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain;
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return GAIN_UNITY;
      3:       return 16'd128;
      4, 5:    return 16'($urandom_range(0, 511));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    pix_in_t dir_pix [3];
    logic [MODE_W-1:0] m;
    int burst;
    bit no_gaps;

    dir_pix[0] = '{8'd0,   8'd255, 8'd128, 8'd0,   8'd255, 8'd127};
    dir_pix[1] = '{8'd255, 8'd0,   8'd1,   8'd255, 8'd0,   8'd128};
    dir_pix[2] = '{8'd255, 8'd255, 8'd200, 8'd0,   8'd0,   8'd255};

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: three pixels per mode code, reset settings first
    for (int k = 0; k < 8; k++) begin
      if (k > 0) begin
        drain();
        write_reg(REG_BLEND_MODE, 16'hFFF8 | 16'(k));
        if (k == 1) begin
          write_reg(REG_BLUE_OFFSET,  16'hFE00 | 16'h0FF);
          write_reg(REG_GREEN_OFFSET, 16'hFE00 | 16'h101);
          write_reg(REG_RED_OFFSET,   16'hFE00 | 16'h100);
          write_reg(REG_BLUE_GAIN,    16'hFFFF);
          write_reg(REG_GREEN_GAIN,   16'd0);
          write_reg(REG_RED_GAIN,     16'd128);   // 1 * 0.5 is an exact half
          write_reg(UNUSED_REG_IDX,   16'h5A5A);
        end
        end_writes();
      end
      for (int j = 0; j < 3; j++) drive_pixel(dir_pix[j], j);
    end

    // random bursts, each under a fresh setting once the pipeline is empty
    while (item_count < RANDOM_ITEMS + 24) begin
      drain();
      m = ($urandom_range(0, 99) < 88) ? MODE_W'($urandom_range(0, 5))
                                        : MODE_W'($urandom_range(6, 7));
      write_reg(REG_BLEND_MODE, {13'($urandom), m});
      if ($urandom_range(0, 1)) write_reg(REG_BLUE_OFFSET,  rand_offset());
      if ($urandom_range(0, 1)) write_reg(REG_GREEN_OFFSET, rand_offset());
      if ($urandom_range(0, 1)) write_reg(REG_RED_OFFSET,   rand_offset());
      if ($urandom_range(0, 1)) write_reg(REG_BLUE_GAIN,    rand_gain());
      if ($urandom_range(0, 1)) write_reg(REG_GREEN_GAIN,   rand_gain());
      if ($urandom_range(0, 1)) write_reg(REG_RED_GAIN,     rand_gain());
      if ($urandom_range(0, 9) == 0) write_reg(UNUSED_REG_IDX, 16'($urandom));
      end_writes();
      burst   = $urandom_range(20, 90);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < burst; j++)
        drive_pixel(rand_pixel(), no_gaps ? 0 : pick_gap());
    end

    drain();
    repeat (4) @(negedge clk);

    $display("%0d pixels under %0d register settings, %0d results compared",
             item_count, setting_count, result_count);
    $display("pixels per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_items[0], mode_items[1], mode_items[2], mode_items[3],
             mode_items[4], mode_items[5], mode_items[6], mode_items[7]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/pbu_pkg.sv
hdl/pbu_channel.sv
hdl/pixel_blend_unit.sv
hdl/pbu_checker.sv
sim/pixel_blend_checker.sv
sim/pixel_blend_unit_tb.sv
